/* sv/ptat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_pkg: shared types and codes of the position trigger table
// holds the command record passed from front to back and the queue status
// ----------------------------------------------------------------------------
`default_nettype none

package ptat_pkg;

  // operation codes carried in tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic REG_ACTIVE_ENTRIES = 1'b0;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               is_load;
    logic               live;       // sample that may fire anything
    logic [3:0]         count;      // entries examined, from entry zero
    logic [2:0]         idx;
    logic               ent_valid;
    logic               ent_kind;
    logic signed [31:0] start_pos;
    logic signed [31:0] stop_pos;
    logic signed [31:0] axis_pos;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

/* sv/ptat_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_front: input beat decode
// unpacks an input beat and classifies it as a load or a live sample
// ----------------------------------------------------------------------------
`default_nettype none

module ptat_front
  import ptat_pkg::*;
(
  input  wire logic [103:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic [3:0]   active_entries,
  output cmd_t              cmd
);

  logic running;

  assign running = in_tdata[101];

  always_comb begin
    cmd.is_load   = (in_tuser == OP_LOAD);
    // a stopped axis or an empty count fires nothing
    cmd.live      = (in_tuser == OP_SAMPLE) && running && (active_entries != 4'd0);
    cmd.count     = active_entries;
    cmd.idx       = in_tdata[2:0];
    cmd.ent_valid = in_tdata[3];
    cmd.ent_kind  = in_tdata[4];
    cmd.start_pos = $signed(in_tdata[36:5]);
    cmd.stop_pos  = $signed(in_tdata[68:37]);
    cmd.axis_pos  = $signed(in_tdata[100:69]);
  end

endmodule

`default_nettype wire

/* sv/ptat_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_queue: command queue
// short fifo of decoded commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ptat_queue
  import ptat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  input  wire cmd_t  push_cmd,
  output logic       push_ready,
  input  wire logic  pop,
  output cmd_t       head,
  output queue_stat_t stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;

  assign stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign push_ready = !stat.full;
  assign push       = push_valid && !stat.full;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/ptat_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_back: table and compare engine
// holds the entry table, compares the valid entries below the count against a sample at once,
// and registers the fire mask for the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module ptat_back
  import ptat_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata
);

  logic                     valid_r [TABLE_ENTRIES];
  logic                     valid_nxt [TABLE_ENTRIES];
  logic                     kind_r [TABLE_ENTRIES];
  logic                     kind_nxt [TABLE_ENTRIES];
  logic                     fired_r [TABLE_ENTRIES];
  logic                     fired_nxt [TABLE_ENTRIES];
  logic signed [31:0]       start_r [TABLE_ENTRIES];
  logic signed [31:0]       stop_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] fire_vec;
  logic [TABLE_ENTRIES-1:0] load_we;
  logic [7:0]               mask_nxt;
  logic [7:0]               mask_r;
  logic                     out_valid_r, out_valid_nxt;

  assign pop = head_valid && (!out_valid_r || out_tready);

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
    localparam int unsigned IDX = i;
    logic signed [31:0] s, e, p;
    logic               en, win, shot;

    assign s  = start_r[i];
    assign e  = stop_r[i];
    assign p  = head.axis_pos;
    assign en = head.live && (32'(head.count) > IDX) && valid_r[i];

    // a bound only counts when it is positive
    assign win = !(((s > 0) && (((s < e) && (p < s)) || ((s > e) && (p > s)))) ||
                   ((e > 0) && (((s < e) && (p > e)) || ((s > e) && (p < e)))));
    assign shot = !fired_r[i] && (p >= s);

    assign fire_vec[i] = en && (kind_r[i] ? shot : win);
    assign load_we[i]  = head.is_load && (32'(head.idx) == IDX);

    always_comb begin
      valid_nxt[i] = valid_r[i];
      kind_nxt[i]  = kind_r[i];
      fired_nxt[i] = fired_r[i];
      if (pop) begin
        if (load_we[i]) begin
          valid_nxt[i] = head.ent_valid;
          kind_nxt[i]  = head.ent_kind;
          fired_nxt[i] = 1'b0;
        end else if (fire_vec[i] && kind_r[i]) begin
          fired_nxt[i] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
        kind_r[i]  <= 1'b0;
        fired_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= valid_nxt[i];
        kind_r[i]  <= kind_nxt[i];
        fired_r[i] <= fired_nxt[i];
      end
    end

    always_ff @(posedge clk) begin
      if (pop && load_we[i]) begin
        start_r[i] <= head.start_pos;
        stop_r[i]  <= head.stop_pos;
      end
    end
  end

  // only the first eight entries own a mask bit
  for (genvar b = 0; b < 8; b++) begin : g_mask
    if (b < TABLE_ENTRIES) begin : g_bit
      assign mask_nxt[b] = fire_vec[b];
    end else begin : g_zero
      assign mask_nxt[b] = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mask_r <= mask_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mask_r;

endmodule

`default_nettype wire

/* sv/position_trigger_action_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_trigger_action_table: position compare trigger table, one axis
// loads table entries and turns axis position samples into fire masks
// ----------------------------------------------------------------------------
// usage:
//   in_* is a stream of beats; in_tuser selects a load (0) or a sample (1).
//   a load writes one table entry and clears its fired mark; a sample compares
//   the axis position against entries 0 .. active_entries-1 at once.
//   every input beat gives exactly one out_* beat with the fire mask
//   (zero for loads, stopped axis or a count of zero).
//   cfg_* is an apb write/read port for active_entries at byte address 0;
//   write it only while the block is idle.
// throughput and path:
//   one beat per cycle sustained while out_tready stays high; an accepted beat
//   is written to the command queue, then popped into the registered mask.
// reset:
//   rst_n clears valid, kind and fired marks, active_entries and the queue;
//   entry positions stay undefined until loaded.
// stall:
//   while out_tready is low the mask register holds; the two-entry command
//   queue keeps taking beats until full, then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module position_trigger_action_table
  import ptat_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: entry_index[2:0], entry_valid[3], entry_kind[4], start_position[36:5],
  //        end_position[68:37], axis_position[100:69], axis_running[101], zero pad
  input  wire logic [103:0] in_tdata,
  // tuser: operation
  input  wire logic         in_tuser,
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: fire_mask[7:0]
  output logic [7:0]        out_tdata,
  // configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [3:0]  active_entries_r;
  logic [3:0]  active_entries_nxt;
  logic        cfg_write;
  cmd_t        front_cmd;
  cmd_t        q_head;
  queue_stat_t q_stat;
  logic        q_pop;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    active_entries_nxt = active_entries_r;
    if (cfg_write && (cfg_paddr[2] == REG_ACTIVE_ENTRIES)) begin
      active_entries_nxt = cfg_pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_entries_r <= 4'd0;
    end else begin
      active_entries_r <= active_entries_nxt;
    end
  end

  // unmapped addresses read as zero
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_ENTRIES) ? {28'd0, active_entries_r} : 32'd0;

  // ---------------- front: decode and classify ----------------
  ptat_front u_front (
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .active_entries (active_entries_r),
    .cmd            (front_cmd)
  );

  // ---------------- command queue ----------------
  ptat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_cmd   (front_cmd),
    .push_ready (in_tready),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // ---------------- back: table, compare, result register ----------------
  ptat_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_stat.empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // queue status never claims full and empty together
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  // a popped command always lands in the result register
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid)
    else $error("popped command left no result");

  // loads and dead samples produce an empty mask
  a_quiet_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_head.is_load || !q_head.live)) |=> (out_tdata == 8'd0))
    else $error("mask set for a load or a dead sample");

  // input backpressure comes only from a full queue
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == !q_stat.full)
    else $error("input ready does not follow queue fill");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the position trigger table
// streams table loads and axis samples with random gaps on both sides,
// predicts each fire mask from a shadow copy of the table and compares it
// beat by beat with the result stream; active_entries is set over several
// values between phases, and one phase holds the receiver off for a long time
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ptat_pkg::*;

  localparam int TABLE_ENTRIES    = 8;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT   = 5000;   // cycles with no beat on any port
  localparam int PHASES           = 7;
  localparam int ITEMS_PER_PHASE  = 100;

  // entry kinds as carried in a load beat
  localparam logic KIND_WINDOW   = 1'b0;
  localparam logic KIND_ONE_SHOT = 1'b1;

  localparam logic [2:0] ACTIVE_ENTRIES_ADDR = 3'(4 * REG_ACTIVE_ENTRIES);

  typedef struct packed {
    logic               op;
    logic [2:0]         idx;
    logic               vld;
    logic               kind;
    logic signed [31:0] start_pos;
    logic signed [31:0] stop_pos;
    logic signed [31:0] axis_pos;
    logic               running;
  } beat_t;

  logic         clk;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata    = '0;
  logic         in_tuser    = OP_LOAD;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [2:0]   cfg_paddr   = '0;
  logic [31:0]  cfg_pwdata  = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // shadow of the table and the register
  logic               tbl_valid [TABLE_ENTRIES];
  logic               tbl_kind  [TABLE_ENTRIES];
  logic signed [31:0] tbl_start [TABLE_ENTRIES];
  logic signed [31:0] tbl_stop  [TABLE_ENTRIES];
  logic               tbl_fired [TABLE_ENTRIES];
  logic [3:0]         active_cnt = '0;

  beat_t      pending_q[$];
  logic [7:0] expected_masks[$];
  int         bound_pool[$];
  beat_t      cur_beat;

  int items_queued  = 0;
  int results_seen  = 0;
  int error_count   = 0;
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int in_gap_left   = 0;
  int out_hold_left = 0;
  int idle_cycles   = 0;
  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;

  position_trigger_action_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ------------------------------------------------------------------------
  // helpers
  // ------------------------------------------------------------------------

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    if (error_count < 40) begin
      $display("[%0t] mismatch: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // stall length: mostly none, sometimes short, rarely long
  function automatic int pick_gap(input int pct);
    if (int'($urandom_range(99)) >= pct) return 0;
    if ($urandom_range(9) == 0) return int'($urandom_range(30, 8));
    return int'($urandom_range(3, 1));
  endfunction

  // fire mask of one beat; updates the shadow table as the block would
  function automatic logic [7:0] compute_fire_mask(input beat_t b);
    logic [7:0] mask;
    int         lim;
    int         s;
    int         e;
    int         p;
    logic       hit;
    mask = '0;
    if (b.op == OP_LOAD) begin
      tbl_valid[b.idx] = b.vld;
      tbl_kind[b.idx]  = b.kind;
      tbl_start[b.idx] = b.start_pos;
      tbl_stop[b.idx]  = b.stop_pos;
      tbl_fired[b.idx] = 1'b0;
    end else begin
      lim = (active_cnt > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(active_cnt);
      p   = b.axis_pos;
      // stopped axis or zero count: nothing fires, fired marks untouched
      if (b.running && lim != 0) begin
        for (int i = 0; i < lim; i++) begin
          if (tbl_valid[i]) begin
            s = tbl_start[i];
            e = tbl_stop[i];
            if (tbl_kind[i] == KIND_WINDOW) begin
              // each bound only counts when positive; equal bounds never block
              hit = 1'b1;
              if (s > 0) begin
                if (s < e && p < s) hit = 1'b0;
                if (s > e && p > s) hit = 1'b0;
              end
              if (e > 0) begin
                if (s < e && p > e) hit = 1'b0;
                if (s > e && p < e) hit = 1'b0;
              end
              mask[i] = hit;
            end else if (!tbl_fired[i] && p >= s) begin
              tbl_fired[i] = 1'b1;
              mask[i]      = 1'b1;
            end
          end
        end
      end
    end
    return mask;
  endfunction

  // positions biased toward loaded bounds, corners and a small range near zero
  function automatic int random_position();
    int sel;
    int k;
    sel = int'($urandom_range(9));
    if (sel <= 3 && bound_pool.size() != 0) begin
      k = int'($urandom_range(bound_pool.size() - 1));
      return bound_pool[k] + int'($urandom_range(2)) - 1;
    end
    if (sel == 4) begin
      case ($urandom_range(4))
        0: return 0;
        1: return 1;
        2: return -1;
        3: return 32'sh7fffffff;
        default: return 32'sh80000000;
      endcase
    end
    if (sel <= 7) return int'($urandom_range(400)) - 200;
    return int'($urandom);
  endfunction

  function automatic beat_t load_beat(input logic [2:0] idx, input logic vld,
                                      input logic kind, input int s, input int e);
    beat_t b;
    b.op        = OP_LOAD;
    b.idx       = idx;
    b.vld       = vld;
    b.kind      = kind;
    b.start_pos = s;
    b.stop_pos  = e;
    b.axis_pos  = $urandom;     // unused on loads, still toggled
    b.running   = 1'($urandom);
    return b;
  endfunction

  function automatic beat_t sample_beat(input int pos, input logic run);
    beat_t b;
    b.op        = OP_SAMPLE;
    b.idx       = 3'($urandom);
    b.vld       = 1'($urandom);
    b.kind      = 1'($urandom);
    b.start_pos = $urandom;
    b.stop_pos  = $urandom;
    b.axis_pos  = pos;
    b.running   = run;
    return b;
  endfunction

  task automatic push_beat(input beat_t b);
    pending_q.push_back(b);
    items_queued++;
  endtask

  task automatic queue_random_items(input int n);
    beat_t b;
    int    s;
    int    e;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        s = random_position();
        e = ($urandom_range(7) == 0) ? s : random_position();
        bound_pool.push_back(s);
        bound_pool.push_back(e);
        while (bound_pool.size() > 16) void'(bound_pool.pop_front());
        b = load_beat(3'($urandom), $urandom_range(6) != 0, 1'($urandom), s, e);
      end else begin
        b = sample_beat(random_position(), $urandom_range(6) != 0);
      end
      push_beat(b);
    end
  endtask

  // every queued beat has come back
  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
  endtask

  // apb write of active_entries, then a read back of the same register
  task automatic write_active_entries(input logic [3:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ACTIVE_ENTRIES_ADDR;
    cfg_pwdata  <= {28'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    active_cnt = val;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {28'd0, val}) report_error("active_entries read back", cfg_prdata,
                                                  {28'd0, val});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // driver: launches queued beats, predicts each one as it is accepted
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_masks.push_back(compute_fire_mask(cur_beat));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_beat  = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_beat.op;
          in_tdata  <= {2'b00, cur_beat.running, cur_beat.axis_pos, cur_beat.stop_pos,
                        cur_beat.start_pos, cur_beat.kind, cur_beat.vld, cur_beat.idx};
          in_gap_left = pick_gap(in_idle_pct);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      out_hold_left  = LONG_HOLD_CYCLES - 1;
      out_tready    <= 1'b0;
    end else if (out_hold_left > 0) begin
      out_hold_left--;
      out_tready <= 1'b0;
    end else begin
      stall = pick_gap(out_idle_pct);
      if (stall > 0) begin
        out_hold_left = stall - 1;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // monitor: each result beat against the oldest expected mask
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_masks.size() == 0) begin
        report_error("result beat with nothing expected", out_tdata, 0);
      end else begin
        want = expected_masks.pop_front();
        if (out_tdata !== want) report_error("fire_mask", out_tdata, want);
      end
    end
  end

  // watchdog: no beat anywhere for too long ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    int phase_count [PHASES] = '{8, 1, 15, 0, 5, 9, 3};
    int phase_in    [PHASES] = '{0, 20, 40, 10, 0, 60, 25};
    int phase_out   [PHASES] = '{0, 20, 40, 30, 10, 60, 5};

    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_kind[i]  = KIND_WINDOW;
      tbl_start[i] = '0;
      tbl_stop[i]  = '0;
      tbl_fired[i] = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // count still zero after reset: a sample fires nothing
    push_beat(load_beat(3'd0, 1'b1, KIND_WINDOW, 0, 0));
    push_beat(sample_beat(10, 1'b1));
    wait_drained();

    write_active_entries(4'd8);
    // one entry per window shape, two one-shots, one skipped entry
    push_beat(load_beat(3'd0, 1'b1, KIND_WINDOW, 100, 200));
    push_beat(load_beat(3'd1, 1'b1, KIND_WINDOW, 200, 100));
    push_beat(load_beat(3'd2, 1'b1, KIND_WINDOW, -50, -10));
    push_beat(load_beat(3'd3, 1'b1, KIND_WINDOW, 5, 5));
    push_beat(load_beat(3'd4, 1'b1, KIND_ONE_SHOT, 150, 0));
    push_beat(load_beat(3'd5, 1'b1, KIND_ONE_SHOT, 32'sh80000000, 32'sh7fffffff));
    push_beat(load_beat(3'd6, 1'b1, KIND_WINDOW, 32'sh7fffffff, 32'sh80000000));
    push_beat(load_beat(3'd7, 1'b0, KIND_ONE_SHOT, 0, 0));
    push_beat(sample_beat(150, 1'b1));
    push_beat(sample_beat(150, 1'b1));             // one-shots already fired
    push_beat(sample_beat(50, 1'b0));              // stopped axis
    push_beat(sample_beat(32'sh7fffffff, 1'b1));
    push_beat(sample_beat(32'sh80000000, 1'b1));
    push_beat(sample_beat(99, 1'b1));
    push_beat(sample_beat(201, 1'b1));
    push_beat(load_beat(3'd4, 1'b1, KIND_ONE_SHOT, 150, 0));   // reload rearms
    push_beat(sample_beat(149, 1'b1));
    push_beat(sample_beat(150, 1'b1));
    push_beat(load_beat(3'd7, 1'b1, KIND_WINDOW, 0, 300));
    push_beat(sample_beat(0, 1'b1));
    push_beat(sample_beat(301, 1'b1));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      repeat (4) @(posedge clk);
      write_active_entries(4'(phase_count[ph]));
      in_idle_pct  = phase_in[ph];
      out_idle_pct = phase_out[ph];
      // sender never pauses in this phase, so the long hold backs up the input
      if (ph == 4) long_hold_req = 1'b1;
      queue_random_items(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_masks.size() != 0) begin
      report_error("expected masks left over", expected_masks.size(), 0);
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/ptat_pkg.sv
sv/ptat_front.sv
sv/ptat_queue.sv
sv/ptat_back.sv
sv/position_trigger_action_table.sv
dv/tb_top.sv
